// ----- src/contrast_autofocus_controller_assert.svh -----
// Assertion macros for the autofocus controller.
`ifndef CONTRAST_AUTOFOCUS_CONTROLLER_ASSERT_SVH
`define CONTRAST_AUTOFOCUS_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
`define CAF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("autofocus assertion failed");
`define CAF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("autofocus assertion failed");
`else
`define CAF_ASSERT_NOW(lbl, ante, cons)
`define CAF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- src/caf_pkg.sv -----
package caf_pkg;

    localparam int MAX_POS  = 64;
    localparam int POS_AW   = $clog2(MAX_POS);
    localparam int CNT_W    = POS_AW + 1;
    localparam int LENS_W   = 10;
    localparam int FOM_W    = 31;
    localparam int NUM_W    = 52;
    localparam int DEN_W    = 32;
    localparam int DCNT_W   = $clog2(NUM_W);
    localparam int MULB_W   = 20;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic [MULB_W-1:0] FOM_SCALE = 20'd1000000;

    localparam logic OP_CTRL  = 1'b0;
    localparam logic OP_FRAME = 1'b1;

    localparam logic [1:0] MODE_MANUAL = 2'd0;
    localparam logic [1:0] MODE_AUTO   = 2'd1;
    localparam logic [1:0] MODE_CONT   = 2'd2;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_SCAN    = 2'd1;
    localparam logic [1:0] ST_FOCUSED = 2'd2;
    localparam logic [1:0] ST_FAILED  = 2'd3;

    localparam logic [1:0] PS_RUN     = 2'd0;
    localparam logic [1:0] PS_PAUSING = 2'd1;
    localparam logic [1:0] PS_PAUSED  = 2'd2;

    localparam logic TRIG_START  = 1'b0;
    localparam logic TRIG_CANCEL = 1'b1;

    localparam logic [1:0] PK_IMMEDIATE = 2'd0;
    localparam logic [1:0] PK_DEFERRED  = 2'd1;
    localparam logic [1:0] PK_RESUME    = 2'd2;

    localparam logic [2:0] REG_INF      = 3'd0;
    localparam logic [2:0] REG_MAC      = 3'd1;
    localparam logic [2:0] REG_CSTEPS   = 3'd2;
    localparam logic [2:0] REG_FRANGE   = 3'd3;
    localparam logic [2:0] REG_FSTEP    = 3'd4;
    localparam logic [2:0] REG_SETTLE   = 3'd5;
    localparam logic [2:0] REG_RATIO    = 3'd6;
    localparam logic [2:0] REG_RFRAMES  = 3'd7;

    typedef enum logic [2:0] {
        PH_IDLE, PH_COARSE, PH_FINE, PH_SETTLE, PH_MONITOR
    } t_phase;

    typedef enum logic [3:0] {
        SQ_IDLE, SQ_CTRL, SQ_MUL, SQ_DSTART, SQ_DIV, SQ_MUL2, SQ_FRAME,
        SQ_RD, SQ_RD2, SQ_GSTART, SQ_GDIV, SQ_GCO, SQ_GFI, SQ_GFEND, SQ_OUT
    } t_seq;

    typedef struct packed {
        logic [LENS_W-1:0] infinity_position;
        logic [LENS_W-1:0] macro_position;
        logic [5:0]        coarse_steps;
        logic [9:0]        fine_range;
        logic [9:0]        fine_step;
        logic [7:0]        settle_frames;
        logic [15:0]       retrigger_ratio;
        logic [7:0]        retrigger_frames;
    } t_cfg;

endpackage

// ----- src/contrast_autofocus_controller.sv -----
// Sequence: a control request gives its result after its control step or, when it starts a
// sweep, after the shared divide and then one position list entry written per cycle.
// A frame passes through the shared divider; when it steps to the next sweep position it also
// reads the list, and it may instead build the fine list or restart a scan first.
// Throughput: one transaction at a time; the next is taken the cycle after the result leaves.
// Reset: synchronous, active low; state registers return to their reset values, the working
// registers and the position list are left unwritten; the list needs no clearing pass.
module contrast_autofocus_controller (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [caf_pkg::ADDR_W-1:0]  paddr,
    input  logic [caf_pkg::DATA_W-1:0]  pwdata,
    output logic [caf_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_operation,
    input  logic                        i_mode_valid,
    input  logic [1:0]                  i_focus_mode,
    input  logic                        i_trigger_valid,
    input  logic                        i_trigger_kind,
    input  logic                        i_pause_valid,
    input  logic [1:0]                  i_pause_kind,
    input  logic                        i_position_valid,
    input  logic [caf_pkg::LENS_W-1:0]  i_manual_position,
    input  logic                        i_stats_valid,
    input  logic [31:0]                 i_focus_gradient,
    input  logic [31:0]                 i_focus_luminance,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_af_mode,
    output logic [1:0]                  o_af_state,
    output logic [1:0]                  o_pause_state,
    output logic [caf_pkg::LENS_W-1:0]  o_frame_lens_position,
    output logic [caf_pkg::LENS_W-1:0]  o_lens_command,
    output logic                        o_lens_update,
    output logic [caf_pkg::FOM_W-1:0]   o_focus_fom,
    output logic                        o_fom_valid
);
    import caf_pkg::*;

`include "contrast_autofocus_controller_assert.svh"

    t_cfg w_cfg;

    caf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    caf_core u_core (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg                 (w_cfg),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_operation           (i_operation),
        .i_mode_valid          (i_mode_valid),
        .i_focus_mode          (i_focus_mode),
        .i_trigger_valid       (i_trigger_valid),
        .i_trigger_kind        (i_trigger_kind),
        .i_pause_valid         (i_pause_valid),
        .i_pause_kind          (i_pause_kind),
        .i_position_valid      (i_position_valid),
        .i_manual_position     (i_manual_position),
        .i_stats_valid         (i_stats_valid),
        .i_focus_gradient      (i_focus_gradient),
        .i_focus_luminance     (i_focus_luminance),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_af_mode             (o_af_mode),
        .o_af_state            (o_af_state),
        .o_pause_state         (o_pause_state),
        .o_frame_lens_position (o_frame_lens_position),
        .o_lens_command        (o_lens_command),
        .o_lens_update         (o_lens_update),
        .o_focus_fom           (o_focus_fom),
        .o_fom_valid           (o_fom_valid)
    );

    // a pending result keeps the input side closed
    `CAF_ASSERT_NOW(a_busy_while_result, o_valid, o_stall)
    // an accepted transaction always closes the input side on the next cycle
    `CAF_ASSERT_NEXT(a_accept_closes, i_valid && !o_stall, o_stall)
    `CAF_ASSERT_NOW(a_no_move_same_lens, o_valid && !o_lens_update,
        o_lens_command == o_frame_lens_position)
    `CAF_ASSERT_NOW(a_fom_zero_when_unused, o_valid && !o_fom_valid, o_focus_fom == '0)

endmodule

// ----- src/caf_regs.sv -----
module caf_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [caf_pkg::ADDR_W-1:0]  paddr,
    input  logic [caf_pkg::DATA_W-1:0]  pwdata,
    output logic [caf_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output caf_pkg::t_cfg               o_cfg
);
    import caf_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] w_idx;
    logic       w_wr;

    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.infinity_position <= '0;
            r_cfg.macro_position    <= '1;
            r_cfg.coarse_steps      <= 6'd16;
            r_cfg.fine_range        <= 10'd32;
            r_cfg.fine_step         <= 10'd4;
            r_cfg.settle_frames     <= 8'd2;
            r_cfg.retrigger_ratio   <= 16'd49152;
            r_cfg.retrigger_frames  <= 8'd5;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_INF:     r_cfg.infinity_position <= pwdata[LENS_W-1:0];
                REG_MAC:     r_cfg.macro_position    <= pwdata[LENS_W-1:0];
                REG_CSTEPS:  r_cfg.coarse_steps      <= pwdata[5:0];
                REG_FRANGE:  r_cfg.fine_range        <= pwdata[9:0];
                REG_FSTEP:   r_cfg.fine_step         <= pwdata[9:0];
                REG_SETTLE:  r_cfg.settle_frames     <= pwdata[7:0];
                REG_RATIO:   r_cfg.retrigger_ratio   <= pwdata[15:0];
                REG_RFRAMES: r_cfg.retrigger_frames  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_INF:     prdata = DATA_W'(r_cfg.infinity_position);
            REG_MAC:     prdata = DATA_W'(r_cfg.macro_position);
            REG_CSTEPS:  prdata = DATA_W'(r_cfg.coarse_steps);
            REG_FRANGE:  prdata = DATA_W'(r_cfg.fine_range);
            REG_FSTEP:   prdata = DATA_W'(r_cfg.fine_step);
            REG_SETTLE:  prdata = DATA_W'(r_cfg.settle_frames);
            REG_RATIO:   prdata = DATA_W'(r_cfg.retrigger_ratio);
            REG_RFRAMES: prdata = DATA_W'(r_cfg.retrigger_frames);
            default:     prdata = '0;
        endcase
    end

endmodule

// ----- src/caf_div.sv -----
// Restoring divider, one quotient bit per cycle.
module caf_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [caf_pkg::NUM_W-1:0]  i_num,
    input  logic [caf_pkg::DEN_W-1:0]  i_den,
    output logic                       o_done,
    output logic [caf_pkg::NUM_W-1:0]  o_quo,
    output logic [caf_pkg::DEN_W-1:0]  o_rem
);
    import caf_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W:0]    w_sh;
    logic [DEN_W:0]    w_diff;
    logic              w_ge;

    assign w_sh   = {r_rem, r_num[NUM_W-1]};
    assign w_ge   = w_sh >= {1'b0, r_den};
    assign w_diff = w_sh - {1'b0, r_den};
    assign o_done = r_done;
    assign o_quo  = r_num;
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(NUM_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) r_busy <= 1'b0;
                else r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_sh[DEN_W-1:0];
        end
    end

endmodule

// ----- src/caf_core.sv -----
module caf_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  caf_pkg::t_cfg               i_cfg,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_operation,
    input  logic                        i_mode_valid,
    input  logic [1:0]                  i_focus_mode,
    input  logic                        i_trigger_valid,
    input  logic                        i_trigger_kind,
    input  logic                        i_pause_valid,
    input  logic [1:0]                  i_pause_kind,
    input  logic                        i_position_valid,
    input  logic [caf_pkg::LENS_W-1:0]  i_manual_position,
    input  logic                        i_stats_valid,
    input  logic [31:0]                 i_focus_gradient,
    input  logic [31:0]                 i_focus_luminance,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_af_mode,
    output logic [1:0]                  o_af_state,
    output logic [1:0]                  o_pause_state,
    output logic [caf_pkg::LENS_W-1:0]  o_frame_lens_position,
    output logic [caf_pkg::LENS_W-1:0]  o_lens_command,
    output logic                        o_lens_update,
    output logic [caf_pkg::FOM_W-1:0]   o_focus_fom,
    output logic                        o_fom_valid
);
    import caf_pkg::*;

    // sequencer and block state
    t_seq               r_seq, n_seq;
    t_phase             r_phase, n_phase;
    logic [1:0]         r_mode, n_mode;
    logic [1:0]         r_st, n_st;
    logic [1:0]         r_ps, n_ps;
    logic               r_paused, n_paused;
    logic               r_def, n_def;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_index, n_index;
    logic [7:0]         r_settle, n_settle;
    logic [LENS_W-1:0]  r_best_pos, n_best_pos;
    logic signed [31:0] r_best_fom, n_best_fom;
    logic [FOM_W-1:0]   r_ref, n_ref;
    logic [7:0]         r_low, n_low;
    logic [LENS_W-1:0]  r_lens, n_lens;

    // per-transaction working registers
    logic [1:0]         r_res_mode, n_res_mode;
    logic [1:0]         r_res_st, n_res_st;
    logic [1:0]         r_res_ps, n_res_ps;
    logic [FOM_W-1:0]   r_fom, n_fom;
    logic               r_fv, n_fv;
    logic [NUM_W-1:0]   r_prod, n_prod;
    logic [9:0]         r_gq, n_gq;
    logic [5:0]         r_gr, n_gr;
    logic [9:0]         r_accq, n_accq;
    logic [5:0]         r_accr, n_accr;
    logic [5:0]         r_gi, n_gi;
    logic [10:0]        r_gp, n_gp;
    logic [LENS_W-1:0]  r_ghi, n_ghi;
    logic [LENS_W-1:0]  r_last, n_last;
    logic [LENS_W-1:0]  r_arrived;

    logic               r_in_mode_valid;
    logic [1:0]         r_in_focus_mode;
    logic               r_in_trigger_valid;
    logic               r_in_trigger_kind;
    logic               r_in_pause_valid;
    logic [1:0]         r_in_pause_kind;
    logic               r_in_position_valid;
    logic [LENS_W-1:0]  r_in_manual;
    logic [31:0]        r_in_grad;
    logic [31:0]        r_in_lum;

    // position list
    logic [LENS_W-1:0]  r_mem [MAX_POS];
    logic [LENS_W-1:0]  r_rd_data;
    logic               w_we;
    logic [POS_AW-1:0]  w_waddr;
    logic [LENS_W-1:0]  w_wdata;

    // shared arithmetic
    logic [31:0]        w_mul_a;
    logic [MULB_W-1:0]  w_mul_b;
    logic [NUM_W-1:0]   w_mul_p;
    logic               w_div_start;
    logic [NUM_W-1:0]   w_div_num;
    logic [DEN_W-1:0]   w_div_den;
    logic               w_div_done;
    logic [NUM_W-1:0]   w_div_quo;
    logic [DEN_W-1:0]   w_div_rem;

    logic               w_accept;
    logic [LENS_W-1:0]  w_inf, w_mac, w_smin, w_smax, w_mag;
    logic               w_neg;
    logic [5:0]         w_csteps;
    logic [9:0]         w_fstep;

    assign w_accept = i_valid && (r_seq == SQ_IDLE);
    assign o_stall  = (r_seq != SQ_IDLE);
    assign o_valid  = (r_seq == SQ_OUT);

    assign w_inf    = i_cfg.infinity_position;
    assign w_mac    = i_cfg.macro_position;
    assign w_neg    = w_mac < w_inf;
    assign w_smin   = w_neg ? w_mac : w_inf;
    assign w_smax   = w_neg ? w_inf : w_mac;
    assign w_mag    = w_smax - w_smin;
    assign w_csteps = (i_cfg.coarse_steps == '0) ? 6'd1 : i_cfg.coarse_steps;
    assign w_fstep  = (i_cfg.fine_step == '0) ? 10'd1 : i_cfg.fine_step;

    assign w_mul_p  = w_mul_a * w_mul_b;

    caf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo),
        .o_rem   (w_div_rem)
    );

    always_comb begin : seq_comb
        logic             v_start;
        logic             v_scan;
        logic [1:0]       v_mode;
        logic [LENS_W-1:0] v_p;
        logic [LENS_W-1:0] v_bp;
        logic [CNT_W-1:0] v_idx;
        logic [6:0]       v_r;
        logic [7:0]       v_lowcnt;
        logic [10:0]      v_lo;
        logic [10:0]      v_hi;
        logic [10:0]      v_sum;

        v_start = 1'b0;
        v_scan  = 1'b0;
        v_mode  = r_mode;
        v_p     = r_in_manual;
        v_bp    = r_best_pos;
        v_idx   = r_index;
        v_r     = '0;
        v_lowcnt = r_low;
        v_lo    = '0;
        v_hi    = '0;
        v_sum   = '0;

        n_seq = r_seq;       n_phase = r_phase;     n_mode = r_mode;
        n_st = r_st;         n_ps = r_ps;           n_paused = r_paused;
        n_def = r_def;       n_count = r_count;     n_index = r_index;
        n_settle = r_settle; n_best_pos = r_best_pos;
        n_best_fom = r_best_fom;                    n_ref = r_ref;
        n_low = r_low;       n_lens = r_lens;
        n_res_mode = r_res_mode; n_res_st = r_res_st; n_res_ps = r_res_ps;
        n_fom = r_fom;       n_fv = r_fv;           n_prod = r_prod;
        n_gq = r_gq;         n_gr = r_gr;           n_accq = r_accq;
        n_accr = r_accr;     n_gi = r_gi;           n_gp = r_gp;
        n_ghi = r_ghi;       n_last = r_last;

        w_mul_a     = r_in_grad;
        w_mul_b     = FOM_SCALE;
        w_div_start = 1'b0;
        w_div_num   = r_prod;
        w_div_den   = r_in_lum;
        w_we        = 1'b0;
        w_waddr     = r_count[POS_AW-1:0];
        w_wdata     = r_gp[LENS_W-1:0];

        unique case (r_seq)
            SQ_IDLE: begin
                if (i_valid) begin
                    n_res_mode = r_mode;
                    n_res_st   = r_st;
                    n_res_ps   = r_ps;
                    n_fom      = '0;
                    n_fv       = 1'b0;
                    if (i_operation == OP_CTRL) n_seq = SQ_CTRL;
                    else if (i_stats_valid && (i_focus_luminance != '0)) n_seq = SQ_MUL;
                    else n_seq = SQ_OUT;
                end
            end
            SQ_CTRL: begin
                n_seq = SQ_OUT;
                if (r_in_mode_valid && (r_in_focus_mode != 2'd3)
                        && (r_in_focus_mode != r_mode)) begin
                    v_mode   = r_in_focus_mode;
                    n_phase  = PH_IDLE;
                    n_count  = '0;
                    n_index  = '0;
                    n_settle = '0;
                    n_low    = '0;
                    n_st     = ST_IDLE;
                    n_paused = 1'b0;
                    n_def    = 1'b0;
                    n_ps     = PS_RUN;
                    if (v_mode == MODE_CONT) begin
                        v_start = 1'b1;
                        n_phase = PH_COARSE;
                    end
                end
                n_mode = v_mode;
                v_scan = (n_phase == PH_COARSE) || (n_phase == PH_FINE)
                      || (n_phase == PH_SETTLE);
                if (r_in_trigger_valid && (v_mode == MODE_AUTO)) begin
                    if ((r_in_trigger_kind == TRIG_START) && (n_phase == PH_IDLE)) begin
                        v_start = 1'b1;
                        n_phase = PH_COARSE;
                    end else if ((r_in_trigger_kind == TRIG_CANCEL) && v_scan) begin
                        v_start  = 1'b0;
                        n_phase  = PH_IDLE;
                        n_count  = '0;
                        n_index  = '0;
                        n_settle = '0;
                        n_low    = '0;
                        n_st     = ST_IDLE;
                    end
                end
                v_scan = (n_phase == PH_COARSE) || (n_phase == PH_FINE)
                      || (n_phase == PH_SETTLE);
                if (r_in_pause_valid && (v_mode == MODE_CONT)) begin
                    if ((r_in_pause_kind == PK_IMMEDIATE) || ((r_in_pause_kind == PK_DEFERRED)
                            && (n_paused || !v_scan))) begin
                        n_paused = 1'b1;
                        n_def    = 1'b0;
                        n_ps     = PS_PAUSED;
                    end else if (r_in_pause_kind == PK_DEFERRED) begin
                        n_def = 1'b1;
                        n_ps  = PS_PAUSING;
                    end else if (r_in_pause_kind == PK_RESUME) begin
                        n_paused = 1'b0;
                        n_def    = 1'b0;
                        n_ps     = PS_RUN;
                        if (n_phase == PH_IDLE) begin
                            v_start = 1'b1;
                            n_phase = PH_COARSE;
                        end
                    end
                end
                if ((v_mode == MODE_MANUAL) && r_in_position_valid) begin
                    if (v_p < w_smin) v_p = w_smin;
                    if (v_p > w_smax) v_p = w_smax;
                    n_lens = v_p;
                end
            end
            SQ_MUL: begin
                n_prod = w_mul_p;
                n_seq  = SQ_DSTART;
            end
            SQ_DSTART: begin
                w_div_start = 1'b1;
                n_seq       = SQ_DIV;
            end
            SQ_DIV: begin
                if (w_div_done) begin
                    n_fom = (|w_div_quo[NUM_W-1:FOM_W]) ? '1 : w_div_quo[FOM_W-1:0];
                    n_fv  = 1'b1;
                    n_seq = SQ_MUL2;
                end
            end
            SQ_MUL2: begin
                w_mul_a = {1'b0, r_ref};
                w_mul_b = MULB_W'(i_cfg.retrigger_ratio);
                n_prod  = w_mul_p;
                n_seq   = SQ_FRAME;
            end
            SQ_FRAME: begin
                n_seq = SQ_OUT;
                if (!r_paused) begin
                    case (r_phase)
                        PH_SETTLE: begin
                            if (r_settle != '0) begin
                                n_settle = r_settle - 1'b1;
                            end else begin
                                n_ref   = (r_best_fom > 32'sd0) ? r_best_fom[FOM_W-1:0] : '0;
                                n_st    = (r_best_fom > 32'sd0) ? ST_FOCUSED : ST_FAILED;
                                n_phase = (r_mode == MODE_CONT) ? PH_MONITOR : PH_IDLE;
                                if (r_def) begin
                                    n_paused = 1'b1;
                                    n_def    = 1'b0;
                                    n_ps     = PS_PAUSED;
                                end
                            end
                        end
                        PH_MONITOR: begin
                            if ((r_ref != '0) && ({r_fom, 16'b0} < r_prod[FOM_W+15:0])) begin
                                v_lowcnt = (r_low == 8'hFF) ? r_low : r_low + 1'b1;
                                n_low    = v_lowcnt;
                                if (v_lowcnt >= i_cfg.retrigger_frames) begin
                                    v_start = 1'b1;
                                    n_phase = PH_COARSE;
                                end
                            end else begin
                                n_low = '0;
                            end
                        end
                        PH_COARSE, PH_FINE: begin
                            if (r_settle != '0) begin
                                n_settle = r_settle - 1'b1;
                            end else begin
                                if ($signed({1'b0, r_fom}) > r_best_fom) begin
                                    n_best_fom = $signed({1'b0, r_fom});
                                    v_bp       = r_lens;
                                end
                                n_best_pos = v_bp;
                                v_idx      = r_index + 1'b1;
                                n_index    = v_idx;
                                if (v_idx < r_count) begin
                                    n_settle = i_cfg.settle_frames;
                                    n_seq    = SQ_RD;
                                end else if (r_phase == PH_COARSE) begin
                                    // fine window clipped to the sweep span
                                    v_sum = {1'b0, w_smin} + {1'b0, i_cfg.fine_range};
                                    v_lo  = ({1'b0, v_bp} >= v_sum)
                                          ? {1'b0, v_bp} - {1'b0, i_cfg.fine_range}
                                          : {1'b0, w_smin};
                                    v_hi  = {1'b0, v_bp} + {1'b0, i_cfg.fine_range};
                                    if (v_hi > {1'b0, w_smax}) v_hi = {1'b0, w_smax};
                                    n_phase    = PH_FINE;
                                    n_index    = '0;
                                    n_settle   = i_cfg.settle_frames;
                                    n_best_fom = -32'sd1;
                                    n_count    = '0;
                                    n_gp       = v_lo;
                                    n_ghi      = v_hi[LENS_W-1:0];
                                    n_lens     = v_lo[LENS_W-1:0];
                                    n_seq      = SQ_GFI;
                                end else begin
                                    n_lens   = v_bp;
                                    n_phase  = PH_SETTLE;
                                    n_settle = i_cfg.settle_frames;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            SQ_RD: begin
                n_seq = SQ_RD2;
            end
            SQ_RD2: begin
                n_lens = r_rd_data;
                n_seq  = SQ_OUT;
            end
            SQ_GSTART: begin
                w_div_start = 1'b1;
                w_div_num   = NUM_W'(w_mag);
                w_div_den   = DEN_W'(w_csteps);
                n_count     = '0;
                n_seq       = SQ_GDIV;
            end
            SQ_GDIV: begin
                if (w_div_done) begin
                    n_gq   = w_div_quo[9:0];
                    n_gr   = w_div_rem[5:0];
                    n_accq = '0;
                    n_accr = '0;
                    n_gi   = '0;
                    n_seq  = SQ_GCO;
                end
            end
            SQ_GCO: begin
                // inf + range*i/steps (minus when macro is below infinity), quotient and remainder kept incrementally
                v_p = w_neg ? w_inf - r_accq : w_inf + r_accq;
                if (((r_count == '0) || (v_p != r_last)) && (r_count < CNT_W'(MAX_POS))) begin
                    w_we    = 1'b1;
                    w_wdata = v_p;
                    n_count = r_count + 1'b1;
                    n_last  = v_p;
                end
                v_r = {1'b0, r_accr} + {1'b0, r_gr};
                if (v_r >= {1'b0, w_csteps}) begin
                    n_accr = 6'(v_r - {1'b0, w_csteps});
                    n_accq = r_accq + r_gq + 1'b1;
                end else begin
                    n_accr = v_r[5:0];
                    n_accq = r_accq + r_gq;
                end
                if (r_gi == w_csteps) n_seq = SQ_OUT;
                else n_gi = r_gi + 1'b1;
            end
            SQ_GFI: begin
                if ((r_gp <= {1'b0, r_ghi}) && (r_count < CNT_W'(MAX_POS))) begin
                    w_we    = 1'b1;
                    w_wdata = r_gp[LENS_W-1:0];
                    n_count = r_count + 1'b1;
                    n_last  = r_gp[LENS_W-1:0];
                    n_gp    = r_gp + {1'b0, w_fstep};
                end else begin
                    n_seq = SQ_GFEND;
                end
            end
            SQ_GFEND: begin
                if (((r_count == '0) || (r_last != r_ghi)) && (r_count < CNT_W'(MAX_POS))) begin
                    w_we    = 1'b1;
                    w_wdata = r_ghi;
                    n_count = r_count + 1'b1;
                    n_last  = r_ghi;
                end
                n_seq = SQ_OUT;
            end
            SQ_OUT: begin
                if (!i_stall) n_seq = SQ_IDLE;
            end
            default: n_seq = SQ_IDLE;
        endcase

        if (v_start) begin
            n_phase    = PH_COARSE;
            n_index    = '0;
            n_settle   = i_cfg.settle_frames;
            n_best_pos = w_inf;
            n_best_fom = -32'sd1;
            n_ref      = '0;
            n_low      = '0;
            n_st       = ST_SCAN;
            n_lens     = w_inf;
            n_seq      = SQ_GSTART;
        end

        if (r_seq == SQ_CTRL) begin
            n_res_mode = n_mode;
            n_res_st   = n_st;
            n_res_ps   = n_ps;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq      <= SQ_IDLE;
            r_phase    <= PH_IDLE;
            r_mode     <= MODE_MANUAL;
            r_st       <= ST_IDLE;
            r_ps       <= PS_RUN;
            r_paused   <= 1'b0;
            r_def      <= 1'b0;
            r_count    <= '0;
            r_index    <= '0;
            r_settle   <= '0;
            r_best_pos <= '0;
            r_best_fom <= -32'sd1;
            r_ref      <= '0;
            r_low      <= '0;
            r_lens     <= '0;
        end else begin
            r_seq      <= n_seq;
            r_phase    <= n_phase;
            r_mode     <= n_mode;
            r_st       <= n_st;
            r_ps       <= n_ps;
            r_paused   <= n_paused;
            r_def      <= n_def;
            r_count    <= n_count;
            r_index    <= n_index;
            r_settle   <= n_settle;
            r_best_pos <= n_best_pos;
            r_best_fom <= n_best_fom;
            r_ref      <= n_ref;
            r_low      <= n_low;
            r_lens     <= n_lens;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_mode <= n_res_mode;
        r_res_st   <= n_res_st;
        r_res_ps   <= n_res_ps;
        r_fom      <= n_fom;
        r_fv       <= n_fv;
        r_prod     <= n_prod;
        r_gq       <= n_gq;
        r_gr       <= n_gr;
        r_accq     <= n_accq;
        r_accr     <= n_accr;
        r_gi       <= n_gi;
        r_gp       <= n_gp;
        r_ghi      <= n_ghi;
        r_last     <= n_last;
        if (w_accept) begin
            r_arrived           <= r_lens;
            r_in_mode_valid     <= i_mode_valid;
            r_in_focus_mode     <= i_focus_mode;
            r_in_trigger_valid  <= i_trigger_valid;
            r_in_trigger_kind   <= i_trigger_kind;
            r_in_pause_valid    <= i_pause_valid;
            r_in_pause_kind     <= i_pause_kind;
            r_in_position_valid <= i_position_valid;
            r_in_manual         <= i_manual_position;
            r_in_grad           <= i_focus_gradient;
            r_in_lum            <= i_focus_luminance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rd_data <= r_mem[r_index[POS_AW-1:0]];
    end

    assign o_af_mode             = r_res_mode;
    assign o_af_state            = r_res_st;
    assign o_pause_state         = r_res_ps;
    assign o_frame_lens_position = r_arrived;
    assign o_lens_command        = r_lens;
    assign o_lens_update         = (r_lens != r_arrived);
    assign o_focus_fom           = r_fom;
    assign o_fom_valid           = r_fv;

endmodule

// ----- tb/contrast_autofocus_controller_tb.sv -----
`timescale 1ns / 100ps

module contrast_autofocus_controller_tb;
    import caf_pkg::*;

    typedef struct {
        logic        op;
        logic        mode_v;
        logic [1:0]  mode;
        logic        trig_v;
        logic        trig_k;
        logic        pause_v;
        logic [1:0]  pause_k;
        logic        pos_v;
        logic [9:0]  pos;
        logic        stats_v;
        logic [31:0] grad;
        logic [31:0] lum;
    } t_req;

    typedef struct {
        logic [1:0]  mode;
        logic [1:0]  state;
        logic [1:0]  pstate;
        logic [9:0]  arrived;
        logic [9:0]  lens;
        logic        upd;
        logic [30:0] fom;
        logic        fom_v;
    } t_focus_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic        pready;
    logic        i_valid;
    logic        o_stall;
    logic        i_operation;
    logic        i_mode_valid;
    logic [1:0]  i_focus_mode;
    logic        i_trigger_valid;
    logic        i_trigger_kind;
    logic        i_pause_valid;
    logic [1:0]  i_pause_kind;
    logic        i_position_valid;
    logic [9:0]  i_manual_position;
    logic        i_stats_valid;
    logic [31:0] i_focus_gradient;
    logic [31:0] i_focus_luminance;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_af_mode;
    logic [1:0]  o_af_state;
    logic [1:0]  o_pause_state;
    logic [9:0]  o_frame_lens_position;
    logic [9:0]  o_lens_command;
    logic        o_lens_update;
    logic [30:0] o_focus_fom;
    logic        o_fom_valid;

    contrast_autofocus_controller DUT (.*);

    // configuration copy
    logic [9:0]  c_inf, c_mac, c_frange, c_fstep;
    logic [5:0]  c_csteps;
    logic [7:0]  c_settle, c_rframes;
    logic [15:0] c_ratio;

    // focus state copy
    t_phase      f_phase;
    logic [1:0]  f_mode, f_state, f_pstate;
    bit          f_paused, f_deferred, f_moved;
    int          f_pos[MAX_POS];
    int          f_count, f_index, f_best_pos, f_best_fom, f_lens;
    int unsigned f_settle, f_ref_fom, f_low;

    t_focus_out  expected_q[$];
    int          errors;
    int          n_items;
    int          n_results;
    int          n_scans;
    bit          no_idle;
    bit          hold_req;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("timeout waiting for results");
        $display("TEST FAILED");
        $finish;
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, n_results);
        errors++;
    endtask

    function automatic void lens_to(input int p);
        if (p < 0) p = 0;
        if (p > 1023) p = 1023;
        if (p != f_lens) begin
            f_lens  = p;
            f_moved = 1'b1;
        end
    endfunction

    function automatic void pos_add(input int p);
        if (f_count < MAX_POS) begin
            f_pos[f_count] = p;
            f_count++;
        end
    endfunction

    function automatic void scan_cancel();
        f_phase  = PH_IDLE;
        f_count  = 0;
        f_index  = 0;
        f_settle = 0;
        f_low    = 0;
        f_state  = ST_IDLE;
    endfunction

    function automatic bool_scanning();
        return f_phase == PH_COARSE || f_phase == PH_FINE || f_phase == PH_SETTLE;
    endfunction

    function automatic void coarse_begin();
        longint span;
        longint steps;
        int p;
        span  = longint'(c_mac) - longint'(c_inf);
        steps = (c_csteps == 0) ? 1 : c_csteps;
        f_count = 0;
        for (longint i = 0; i <= steps; i++) begin
            p = int'(longint'(c_inf) + span * i / steps);
            if (f_count == 0 || f_pos[f_count-1] != p) pos_add(p);
        end
        f_phase    = PH_COARSE;
        f_index    = 0;
        f_settle   = c_settle;
        f_best_pos = c_inf;
        f_best_fom = -1;
        f_ref_fom  = 0;
        f_low      = 0;
        f_state    = ST_SCAN;
        n_scans++;
        lens_to(f_pos[0]);
    endfunction

    function automatic void fine_begin();
        int lo, hi, p, step, smin, smax;
        smin = (c_inf < c_mac) ? c_inf : c_mac;
        smax = (c_inf < c_mac) ? c_mac : c_inf;
        lo   = f_best_pos - int'(c_frange);
        hi   = f_best_pos + int'(c_frange);
        step = (c_fstep == 0) ? 1 : c_fstep;
        if (lo < smin) lo = smin;
        if (hi > smax) hi = smax;
        f_count = 0;
        for (p = lo; p <= hi && f_count < MAX_POS; p += step) pos_add(p);
        if (f_count == 0 || f_pos[f_count-1] != hi) pos_add(hi);
        f_phase    = PH_FINE;
        f_index    = 0;
        f_settle   = c_settle;
        f_best_fom = -1;
        lens_to(f_pos[0]);
    endfunction

    function automatic void apply_request(input t_req r);
        int lo, hi, p;
        if (r.mode_v && r.mode <= MODE_CONT && r.mode != f_mode) begin
            f_mode = r.mode;
            scan_cancel();
            f_paused   = 0;
            f_deferred = 0;
            f_pstate   = PS_RUN;
            if (r.mode == MODE_CONT) coarse_begin();
        end
        if (r.trig_v && f_mode == MODE_AUTO) begin
            if (r.trig_k == TRIG_START && f_phase == PH_IDLE) coarse_begin();
            else if (r.trig_k == TRIG_CANCEL && bool_scanning()) scan_cancel();
        end
        if (r.pause_v && f_mode == MODE_CONT) begin
            if (r.pause_k == PK_IMMEDIATE ||
                (r.pause_k == PK_DEFERRED && (f_paused || !bool_scanning()))) begin
                f_paused   = 1;
                f_deferred = 0;
                f_pstate   = PS_PAUSED;
            end else if (r.pause_k == PK_DEFERRED) begin
                f_deferred = 1;
                f_pstate   = PS_PAUSING;
            end else if (r.pause_k == PK_RESUME) begin
                f_paused   = 0;
                f_deferred = 0;
                f_pstate   = PS_RUN;
                if (f_phase == PH_IDLE) coarse_begin();
            end
        end
        if (f_mode == MODE_MANUAL && r.pos_v) begin
            lo = (c_inf < c_mac) ? c_inf : c_mac;
            hi = (c_inf < c_mac) ? c_mac : c_inf;
            p  = r.pos;
            if (p < lo) p = lo;
            if (p > hi) p = hi;
            lens_to(p);
        end
    endfunction

    function automatic void apply_frame(input int unsigned fom);
        if (f_paused) return;
        if (f_phase == PH_SETTLE) begin
            if (f_settle != 0) begin
                f_settle--;
                return;
            end
            f_ref_fom = (f_best_fom > 0) ? f_best_fom : 0;
            f_state   = (f_best_fom > 0) ? ST_FOCUSED : ST_FAILED;
            f_phase   = (f_mode == MODE_CONT) ? PH_MONITOR : PH_IDLE;
            if (f_deferred) begin
                f_paused   = 1;
                f_deferred = 0;
                f_pstate   = PS_PAUSED;
            end
            return;
        end
        if (f_phase == PH_MONITOR) begin
            if (f_ref_fom > 0 &&
                (longint'(fom) << 16) < longint'(f_ref_fom) * longint'(c_ratio)) begin
                if (f_low < 255) f_low++;
                if (f_low >= c_rframes) coarse_begin();
            end else begin
                f_low = 0;
            end
            return;
        end
        if (f_phase != PH_COARSE && f_phase != PH_FINE) return;
        if (f_settle != 0) begin
            f_settle--;
            return;
        end
        if (int'(fom) > f_best_fom) begin
            f_best_fom = fom;
            f_best_pos = f_pos[f_index % MAX_POS];
        end
        f_index++;
        if (f_index < f_count) begin
            lens_to(f_pos[f_index % MAX_POS]);
            f_settle = c_settle;
            return;
        end
        if (f_phase == PH_COARSE) begin
            fine_begin();
        end else begin
            lens_to(f_best_pos);
            f_phase  = PH_SETTLE;
            f_settle = c_settle;
        end
    endfunction

    function automatic t_focus_out focus_predict(input t_req r);
        t_focus_out o;
        longint unsigned q;
        o.arrived = 10'(f_lens);
        o.fom     = '0;
        o.fom_v   = 1'b0;
        o.mode    = f_mode;
        o.state   = f_state;
        o.pstate  = f_pstate;
        f_moved   = 0;
        if (r.op == OP_CTRL) begin
            apply_request(r);
            o.mode   = f_mode;
            o.state  = f_state;
            o.pstate = f_pstate;
        end else if (r.stats_v && r.lum != 0) begin
            q = longint'(r.grad) * 64'd1000000 / longint'(r.lum);
            if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
            o.fom   = q[30:0];
            o.fom_v = 1'b1;
            apply_frame(q[31:0]);
        end
        o.lens = 10'(f_lens);
        o.upd  = f_moved;
        return o;
    endfunction

    function automatic void focus_reset();
        c_inf = 0; c_mac = 1023; c_csteps = 16; c_frange = 32; c_fstep = 4;
        c_settle = 2; c_ratio = 49152; c_rframes = 5;
        f_phase = PH_IDLE; f_mode = MODE_MANUAL; f_state = ST_IDLE; f_pstate = PS_RUN;
        f_paused = 0; f_deferred = 0;
        f_count = 0; f_index = 0; f_settle = 0;
        f_best_pos = 0; f_best_fom = -1; f_ref_fom = 0; f_low = 0; f_lens = 0;
    endfunction

    // one transaction on the input channel; valid is left high after acceptance
    task automatic send_item(input t_req r);
        int gap;
        t_focus_out e;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_operation       <= r.op;
        i_mode_valid      <= r.mode_v;
        i_focus_mode      <= r.mode;
        i_trigger_valid   <= r.trig_v;
        i_trigger_kind    <= r.trig_k;
        i_pause_valid     <= r.pause_v;
        i_pause_kind      <= r.pause_k;
        i_position_valid  <= r.pos_v;
        i_manual_position <= r.pos;
        i_stats_valid     <= r.stats_v;
        i_focus_gradient  <= r.grad;
        i_focus_luminance <= r.lum;
        do @(posedge i_clk); while (o_stall);
        e = focus_predict(r);
        expected_q.insert(expected_q.size(), e);
        n_items++;
    endtask

    function automatic t_req ctrl_req(input bit mv, input logic [1:0] m, input bit tv,
                                      input bit tk, input bit pv, input logic [1:0] pk,
                                      input bit posv, input logic [9:0] pos);
        t_req r;
        r = '{op: OP_CTRL, mode_v: mv, mode: m, trig_v: tv, trig_k: tk, pause_v: pv,
              pause_k: pk, pos_v: posv, pos: pos, stats_v: $urandom_range(0, 1),
              grad: $urandom, lum: $urandom};
        return r;
    endfunction

    function automatic t_req frame_req(input bit sv, input logic [31:0] g,
                                       input logic [31:0] l);
        t_req r;
        r = '{op: OP_FRAME, mode_v: $urandom_range(0, 1), mode: $urandom_range(0, 3),
              trig_v: $urandom_range(0, 1), trig_k: $urandom_range(0, 1),
              pause_v: $urandom_range(0, 1), pause_k: $urandom_range(0, 3),
              pos_v: $urandom_range(0, 1), pos: $urandom, stats_v: sv, grad: g, lum: l};
        return r;
    endfunction

    task automatic set_mode(input logic [1:0] m);
        send_item(ctrl_req(1, m, 0, TRIG_START, 0, PK_IMMEDIATE, 0, 0));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // setup and access phase of one write; the caller releases the bus afterwards
    task automatic reg_write(input logic [2:0] idx, input int unsigned val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_INF:     c_inf     = val[9:0];
            REG_MAC:     c_mac     = val[9:0];
            REG_CSTEPS:  c_csteps  = val[5:0];
            REG_FRANGE:  c_frange  = val[9:0];
            REG_FSTEP:   c_fstep   = val[9:0];
            REG_SETTLE:  c_settle  = val[7:0];
            REG_RATIO:   c_ratio   = val[15:0];
            REG_RFRAMES: c_rframes = val[7:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int unsigned inf, mac, cs, fr, fs, st, ra, rf);
        wait_drained();
        reg_write(REG_INF, inf);
        reg_write(REG_MAC, mac);
        reg_write(REG_CSTEPS, cs);
        reg_write(REG_FRANGE, fr);
        reg_write(REG_FSTEP, fs);
        reg_write(REG_SETTLE, st);
        reg_write(REG_RATIO, ra);
        reg_write(REG_RFRAMES, rf);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // receiver: one stall draw per result, long hold-off on request
    initial begin
        int n;
        t_focus_out e;
        i_stall <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            n = no_idle ? 0 : $urandom_range(0, 5);
            if (hold_req) begin
                hold_req = 0;
                n = 400;
            end
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
            n_results++;
            if (expected_q.size() == 0) begin
                report("unexpected result transaction", 1, 0);
            end else begin
                e = expected_q.pop_front();
                if (o_af_mode != e.mode)  report("af_mode", o_af_mode, e.mode);
                if (o_af_state != e.state) report("af_state", o_af_state, e.state);
                if (o_pause_state != e.pstate)
                    report("pause_state", o_pause_state, e.pstate);
                if (o_frame_lens_position != e.arrived)
                    report("frame_lens_position", o_frame_lens_position, e.arrived);
                if (o_lens_command != e.lens) report("lens_command", o_lens_command, e.lens);
                if (o_lens_update != e.upd) report("lens_update", o_lens_update, e.upd);
                if (o_focus_fom != e.fom) report("focus_fom", o_focus_fom, e.fom);
                if (o_fom_valid != e.fom_v) report("fom_valid", o_fom_valid, e.fom_v);
            end
        end
    end

    task automatic test_manual();
        configure(100, 900, 1, 1, 1, 0, 65535, 1);
        send_item(ctrl_req(0, 0, 0, 0, 0, 0, 1, 10'd0));
        send_item(ctrl_req(0, 0, 0, 0, 0, 0, 1, 10'd1023));
        send_item(ctrl_req(0, 0, 0, 0, 0, 0, 1, 10'd512));
        // reversed span: infinity above macro
        configure(1023, 0, 1, 1, 1, 0, 65535, 1);
        send_item(ctrl_req(0, 0, 0, 0, 0, 0, 1, 10'd300));
        send_item(ctrl_req(1, 2'd3, 0, 0, 1, 2'd3, 1, 10'd0));
    endtask

    task automatic test_frames_unusable();
        send_item(frame_req(0, 32'hFFFF_FFFF, 32'd1));
        send_item(frame_req(1, 32'hFFFF_FFFF, 32'd0));
        send_item(frame_req(1, 32'hFFFF_FFFF, 32'd1));
        send_item(frame_req(1, 32'd0, 32'hFFFF_FFFF));
    endtask

    task automatic test_auto_scan();
        configure(10, 20, 0, 1, 0, 0, 0, 0);
        set_mode(MODE_AUTO);
        send_item(ctrl_req(0, 0, 1, TRIG_START, 0, 0, 0, 0));
        repeat (6) send_item(frame_req(1, $urandom, 32'd1000));
        send_item(ctrl_req(0, 0, 1, TRIG_START, 0, 0, 0, 0));
        send_item(ctrl_req(0, 0, 1, TRIG_CANCEL, 0, 0, 0, 0));
    endtask

    task automatic test_continuous();
        configure(0, 30, 1, 1, 1, 0, 65535, 2);
        set_mode(MODE_CONT);
        send_item(ctrl_req(0, 0, 0, 0, 1, PK_DEFERRED, 0, 0));
        repeat (6) send_item(frame_req(1, 32'd5000, 32'd1000));
        send_item(ctrl_req(0, 0, 0, 0, 1, PK_RESUME, 0, 0));
        repeat (3) send_item(frame_req(1, 32'd1, 32'd1000));
        send_item(ctrl_req(0, 0, 0, 0, 1, PK_IMMEDIATE, 0, 0));
    endtask

    function automatic t_req random_req();
        t_req r;
        logic [1:0] pk;
        if ($urandom_range(0, 99) < 82) begin
            if ($urandom_range(0, 19) == 0)
                r = frame_req($urandom_range(0, 1), $urandom, $urandom_range(0, 1) ? 0 : $urandom);
            else
                r = frame_req(1, $urandom >> $urandom_range(0, 31),
                              ($urandom >> $urandom_range(0, 31)) | 32'd1);
        end else begin
            pk = $urandom_range(0, 3);
            r = ctrl_req($urandom_range(0, 9) == 0, $urandom_range(0, 3),
                         $urandom_range(0, 2) == 0, $urandom_range(0, 3) == 0,
                         $urandom_range(0, 3) == 0, pk,
                         $urandom_range(0, 1), $urandom);
        end
        return r;
    endfunction

    task automatic test_random(input int count, input logic [1:0] m);
        set_mode(m);
        if (m == MODE_AUTO) send_item(ctrl_req(0, 0, 1, TRIG_START, 0, 0, 0, 0));
        for (int k = 0; k < count; k++) begin
            if (m == MODE_AUTO && k % 20 == 0)
                send_item(ctrl_req(0, 0, 1, TRIG_START, 0, 0, 0, 0));
            else
                send_item(random_req());
        end
    endtask

    task automatic test_backpressure();
        hold_req = 1;
        repeat (12) send_item(random_req());
        wait_drained();
        no_idle = 1;
        repeat (40) send_item(random_req());
        no_idle = 0;
    endtask

    initial begin
        errors = 0; n_items = 0; n_results = 0; n_scans = 0;
        no_idle = 0; hold_req = 0;
        psel <= 0; penable <= 0; pwrite <= 0; paddr <= '0; pwdata <= '0;
        i_valid <= 0; i_operation <= 0; i_mode_valid <= 0; i_focus_mode <= 0;
        i_trigger_valid <= 0; i_trigger_kind <= 0; i_pause_valid <= 0;
        i_pause_kind <= 0; i_position_valid <= 0; i_manual_position <= 0;
        i_stats_valid <= 0; i_focus_gradient <= 0; i_focus_luminance <= 0;
        i_rst_n <= 1'b0;
        focus_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_frames_unusable();
        test_manual();
        test_auto_scan();
        test_continuous();

        configure(0, 1023, 16, 32, 4, 2, 49152, 5);
        test_random(150, MODE_CONT);
        configure(1023, 0, 63, 1023, 1, 0, 65535, 255);
        test_random(100, MODE_AUTO);
        configure(0, 0, 1, 1, 1023, 0, 1, 1);
        test_random(100, MODE_CONT);
        configure(5, 700, 0, 1023, 0, 255, 0, 0);
        test_random(60, MODE_AUTO);
        configure($urandom_range(0, 400), $urandom_range(600, 1023), $urandom_range(1, 8),
                  $urandom_range(1, 60), $urandom_range(1, 20), $urandom_range(0, 2),
                  $urandom_range(30000, 65535), $urandom_range(1, 4));
        test_random(200, MODE_CONT);
        test_backpressure();
        configure($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(1, 8),
                  $urandom_range(1, 1023), $urandom_range(1, 1023), $urandom_range(0, 1),
                  $urandom, $urandom_range(1, 255));
        test_random(130, MODE_AUTO);
        test_random(100, MODE_MANUAL);

        wait_drained();
        repeat (200) @(posedge i_clk);
        $display("sent %0d transactions, checked %0d results, %0d scans started",
                 n_items, n_results, n_scans);
        $display("covered manual, auto and continuous modes, pauses and several register sets");
        if (errors == 0 && expected_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
